>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define WGSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wgsd assertion failed");

// property checked on every edge, reset included
`define WGSD_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wgsd assertion failed");

`endif

>>> rtl/core/wgsd_pkg.sv
// ----------------------------------------------------------------------------
// wgsd_pkg
// Types, codes and helpers of the weighted grid stencil derivative block.
// ----------------------------------------------------------------------------
package wgsd_pkg;

  localparam int DATA_W    = 32;
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 40;
  localparam int ACC_W     = 56;
  localparam int PROD_W    = 64;
  localparam int RND_W     = 48;
  localparam int COORD_W   = 12;
  localparam int OP_W      = 4;
  localparam int CFG_IDX_W = 3;
  localparam int TERM_W    = 3;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_MAX_LAYERS = 8;

  localparam logic [OP_W-1:0] OP_LOAD_X  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD_C1 = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD_C8 = 4'd8;
  localparam logic [OP_W-1:0] OP_LOAD_K  = 4'd9;
  localparam logic [OP_W-1:0] OP_QUERY   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYERED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYERS  = 3'd4;

  localparam logic [TERM_W-1:0] LAST_TERM = 3'd6;
  localparam logic [TERM_W-1:0] COEF_C8   = 3'd7;

  // neighbour taps: row offset + 1 and column offset + 2, in stencil order
  localparam logic [1:0] ROW_TAP [7] = '{2'd0, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1};
  localparam logic [1:0] COL_TAP [7] = '{2'd2, 2'd2, 2'd3, 2'd1, 2'd0, 2'd1, 2'd2};

  // clip to q16.16, flag in the top bit
  function automatic logic [DATA_W:0] sat_q(input logic [ACC_W-1:0] v);
    logic ovf;
    ovf = (v[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){v[ACC_W-1]}});
    if (!ovf) begin
      sat_q = {1'b0, v[DATA_W-1:0]};
    end else if (v[ACC_W-1]) begin
      sat_q = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_q = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/core/wgsd_ram.sv
// ----------------------------------------------------------------------------
// wgsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wgsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/wgsd_mac.sv
// ----------------------------------------------------------------------------
// wgsd_mac
// Shared q16.16 multiplier: registered product, rounded output.
// ----------------------------------------------------------------------------
module wgsd_mac (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [wgsd_pkg::DATA_W-1:0] a,
  input  logic signed [wgsd_pkg::DATA_W-1:0] b,
  output logic signed [wgsd_pkg::RND_W-1:0]  rnd
);
  import wgsd_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

  // round to nearest, ties upward
  assign biased = prod + PROD_W'(32768);
  assign rnd    = biased[PROD_W-1:PROD_W-RND_W];

endmodule

>>> rtl/core/weighted_grid_stencil_derivative.sv
// ----------------------------------------------------------------------------
// weighted_grid_stencil_derivative
// Seven-point weighted stencil with optional layer coupling, q16.16.
// ----------------------------------------------------------------------------
// Requests arrive on s_tvalid/s_tready/s_tdata; each is a load (grid value,
// one of eight cell coefficients, or a coupling entry) or a query. Loads are
// written into block RAM in the cycle they are taken and give no response.
// A query walks the seven stencil taps through one shared multiplier, each
// tap as a RAM read, a multiply, then a round and accumulate. In layered
// mode each layer adds a coupling term (two grid reads, gain and c8
// products, clip, product with k). The shared multiplier and the single
// read port of the grid RAM set the pace of a query.
// s_tready is low while a query is in progress; the next request may be
// taken while the previous response still waits on m_tvalid/m_tready, and a
// stalled receiver only holds the following query at its final step.
// Configuration writes use cfg_valid/cfg_ready (always ready). Reset clears
// control state and restores register defaults; RAM contents stay undefined
// until written, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module weighted_grid_stencil_derivative #(
  parameter int MAX_ROWS   = wgsd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = wgsd_pkg::DEF_MAX_COLS,
  parameter int MAX_LAYERS = wgsd_pkg::DEF_MAX_LAYERS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // operation[3:0], row[9:4], col[15:10], layer[18:16], value[50:19], zero pad
  input  logic [wgsd_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // derivative[31:0], saturated[32], zero pad
  output logic [wgsd_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wgsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wgsd_pkg::DATA_W-1:0]        cfg_data
);
  import wgsd_pkg::*;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LAY_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CELL_W = LAY_W + ROW_W + COL_W;
  localparam int COEF_W = TERM_W + CELL_W;
  localparam int K_W    = 2 * LAY_W;
  localparam int M_W    = $clog2(MAX_LAYERS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ST_RD, S_ST_MUL, S_ST_ACC, S_CA_RD, S_CA_MUL,
    S_CB_MUL, S_CT_SUM, S_CK_MUL, S_CK_ACC, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic              layered;
  logic [DATA_W-1:0] gain;
  logic [6:0]        rows_cfg;
  logic [6:0]        cols_cfg;
  logic [3:0]        layers_cfg;

  // request fields
  logic [OP_W-1:0]   s_op;
  logic [5:0]        s_row;
  logic [5:0]        s_col;
  logic [2:0]        s_layer;
  logic [DATA_W-1:0] s_value;
  logic [2:0]        lay_in;

  logic [COORD_W-1:0] rows_eff, cols_eff, lays_eff;
  logic               in_grid, k_ok, take;

  // query context
  logic [5:0]             q_row, q_col;
  logic [LAY_W-1:0]       q_lay;
  logic [TERM_W-1:0]      term;
  logic [M_W-1:0]         m;
  logic                   nb_ok;
  logic [ACC_W-1:0]       acc;
  logic [RND_W-1:0]       tmp;
  logic [ACC_W-1:0]       tsum;
  logic [DATA_W-1:0]      kreg;
  logic                   flag;

  logic [COORD_W-1:0]     nr, nc;
  logic [DATA_W:0]        tsat, osat;

  // ram ports
  logic              g_we, g_re, c_we, c_re, k_we, k_re;
  logic [CELL_W-1:0] g_waddr, g_raddr, cell_w;
  logic [COEF_W-1:0] c_waddr, c_raddr;
  logic [K_W-1:0]    k_waddr, k_raddr;
  logic [DATA_W-1:0] g_rdata, c_rdata, k_rdata;

  // multiplier
  logic              mac_en;
  logic [DATA_W-1:0] mac_a, mac_b;
  logic [RND_W-1:0]  rnd;
  logic [ACC_W-1:0]  rnd_ext;

  assign s_op    = s_tdata[3:0];
  assign s_row   = s_tdata[9:4];
  assign s_col   = s_tdata[15:10];
  assign s_layer = s_tdata[18:16];
  assign s_value = s_tdata[50:19];
  assign lay_in  = layered ? s_layer : 3'd0;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign take      = s_tvalid && s_tready;

  always_comb begin
    if (rows_cfg == 7'd0) begin
      rows_eff = COORD_W'(1);
    end else if (COORD_W'(rows_cfg) > COORD_W'(MAX_ROWS)) begin
      rows_eff = COORD_W'(MAX_ROWS);
    end else begin
      rows_eff = COORD_W'(rows_cfg);
    end
    if (cols_cfg == 7'd0) begin
      cols_eff = COORD_W'(1);
    end else if (COORD_W'(cols_cfg) > COORD_W'(MAX_COLS)) begin
      cols_eff = COORD_W'(MAX_COLS);
    end else begin
      cols_eff = COORD_W'(cols_cfg);
    end
    if (!layered || layers_cfg == 4'd0) begin
      lays_eff = COORD_W'(1);
    end else if (COORD_W'(layers_cfg) > COORD_W'(MAX_LAYERS)) begin
      lays_eff = COORD_W'(MAX_LAYERS);
    end else begin
      lays_eff = COORD_W'(layers_cfg);
    end
  end

  assign in_grid = (COORD_W'(s_row) < rows_eff) && (COORD_W'(s_col) < cols_eff)
                   && (COORD_W'(lay_in) < lays_eff);
  assign k_ok    = (COORD_W'(lay_in) < lays_eff) && (COORD_W'(s_col) < lays_eff);

  // load writes
  assign cell_w  = {LAY_W'(lay_in), ROW_W'(s_row), COL_W'(s_col)};
  assign g_waddr = cell_w;
  assign c_waddr = {TERM_W'(s_op - OP_LOAD_C1), cell_w};
  assign k_waddr = {LAY_W'(lay_in), LAY_W'(s_col)};

  always_comb begin
    g_we = 1'b0;
    c_we = 1'b0;
    k_we = 1'b0;
    if (take) begin
      unique case (s_op) inside
        OP_LOAD_X:                g_we = in_grid;
        [OP_LOAD_C1:OP_LOAD_C8]:  c_we = in_grid;
        OP_LOAD_K:                k_we = k_ok;
        default: ;
      endcase
    end
  end

  // stencil neighbour of the current tap
  assign nr = COORD_W'(q_row) + COORD_W'(ROW_TAP[term]) - COORD_W'(1);
  assign nc = COORD_W'(q_col) + COORD_W'(COL_TAP[term]) - COORD_W'(2);

  // read addresses
  always_comb begin
    g_re    = 1'b0;
    c_re    = 1'b0;
    k_re    = 1'b0;
    g_raddr = {q_lay, ROW_W'(nr), COL_W'(nc)};
    c_raddr = {term, q_lay, ROW_W'(q_row), COL_W'(q_col)};
    k_raddr = {q_lay, LAY_W'(m)};
    unique case (state)
      S_ST_RD: begin
        g_re = 1'b1;
        c_re = 1'b1;
      end
      S_CA_RD: begin
        g_re    = 1'b1;
        k_re    = 1'b1;
        g_raddr = {LAY_W'(m), ROW_W'(q_row), COL_W'(q_col)};
      end
      S_CA_MUL: begin
        g_re    = 1'b1;
        c_re    = 1'b1;
        g_raddr = {LAY_W'(m), ROW_W'(q_row), COL_W'(q_col - 6'd1)};
        c_raddr = {COEF_C8, LAY_W'(m), ROW_W'(q_row), COL_W'(q_col)};
      end
      default: ;
    endcase
  end

  assign tsat = sat_q(tsum);
  assign osat = sat_q(acc);

  always_comb begin
    mac_en = 1'b0;
    mac_a  = c_rdata;
    mac_b  = nb_ok ? g_rdata : '0;
    unique case (state)
      S_ST_MUL: mac_en = 1'b1;
      S_CA_MUL: begin
        mac_en = 1'b1;
        mac_a  = gain;
        mac_b  = g_rdata;
      end
      S_CB_MUL: begin
        mac_en = 1'b1;
        mac_b  = (q_col != 6'd0) ? g_rdata : '0;
      end
      S_CK_MUL: begin
        mac_en = 1'b1;
        mac_a  = tsat[DATA_W-1:0];
        mac_b  = kreg;
      end
      default: ;
    endcase
  end

  assign rnd_ext = {{(ACC_W-RND_W){rnd[RND_W-1]}}, rnd};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      layered    <= 1'b0;
      gain       <= '0;
      rows_cfg   <= 7'd64;
      cols_cfg   <= 7'd64;
      layers_cfg <= 4'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LAYERED: layered    <= cfg_data[0];
          CFG_GAIN:    gain       <= cfg_data;
          CFG_ROWS:    rows_cfg   <= cfg_data[6:0];
          CFG_COLS:    cols_cfg   <= cfg_data[6:0];
          CFG_LAYERS:  layers_cfg <= cfg_data[3:0];
          default: ;
        endcase
      end
      // the final step sets the response itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && s_op == OP_QUERY) begin
            q_row <= s_row;
            q_col <= s_col;
            q_lay <= LAY_W'(lay_in);
            term  <= '0;
            m     <= '0;
            acc   <= '0;
            flag  <= 1'b0;
            // a query outside the grid answers zero
            state <= in_grid ? S_ST_RD : S_DONE;
          end
        end
        S_ST_RD: begin
          nb_ok <= (nr < rows_eff) && (nc < cols_eff);
          state <= S_ST_MUL;
        end
        S_ST_MUL: state <= S_ST_ACC;
        S_ST_ACC: begin
          acc <= (term == LAST_TERM) ? acc - rnd_ext : acc + rnd_ext;
          if (term == LAST_TERM) begin
            state <= layered ? S_CA_RD : S_DONE;
          end else begin
            term  <= term + 3'd1;
            state <= S_ST_RD;
          end
        end
        S_CA_RD:  state <= S_CA_MUL;
        S_CA_MUL: begin
          kreg  <= k_rdata;
          state <= S_CB_MUL;
        end
        S_CB_MUL: begin
          tmp   <= rnd;
          state <= S_CT_SUM;
        end
        S_CT_SUM: begin
          tsum  <= {{(ACC_W-RND_W){tmp[RND_W-1]}}, tmp} + rnd_ext;
          state <= S_CK_MUL;
        end
        S_CK_MUL: begin
          flag  <= flag | tsat[DATA_W];
          state <= S_CK_ACC;
        end
        S_CK_ACC: begin
          acc <= acc + rnd_ext;
          m   <= m + M_W'(1);
          state <= (COORD_W'(m) + COORD_W'(1) < lays_eff) ? S_CA_RD : S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(M_TDATA_W-DATA_W-1){1'b0}}, flag | osat[DATA_W],
                         osat[DATA_W-1:0]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  wgsd_ram #(.WIDTH(DATA_W), .DEPTH(2 ** CELL_W)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(s_value),
    .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
  );

  wgsd_ram #(.WIDTH(DATA_W), .DEPTH(2 ** COEF_W)) u_coef (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(s_value),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  wgsd_ram #(.WIDTH(DATA_W), .DEPTH(2 ** K_W)) u_coup (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(s_value),
    .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
  );

  wgsd_mac u_mac (
    .clk(clk), .en(mac_en), .a(mac_a), .b(mac_b), .rnd(rnd)
  );

endmodule

>>> rtl/core/wgsd_checker.sv
// ----------------------------------------------------------------------------
// wgsd_props
// Port-level checks of the stencil derivative block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wgsd_props (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [wgsd_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [wgsd_pkg::M_TDATA_W-1:0] m_tdata
);
  import wgsd_pkg::*;

  // a stalled response keeps its value
  `WGSD_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // a query request blocks the next request
  `WGSD_ASSERT(a_query_busy, clk, rst, s_tvalid && s_tready && s_tdata[3:0] == OP_QUERY |=> !s_tready)

  // padding bits above the flag stay zero
  `WGSD_ASSERT(a_pad, clk, rst, m_tvalid |-> m_tdata[M_TDATA_W-1:DATA_W+1] == '0)

  // nothing is offered straight after reset
  `WGSD_ASSERT_ALL(a_reset, clk, rst |=> !m_tvalid)

endmodule

bind weighted_grid_stencil_derivative wgsd_props u_wgsd_props (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
